FILE: hw/rtl/line_sensor_pd_steering_assert.svh
// Assertion macros shared by the line sensor steering checks.
`ifndef LINE_SENSOR_PD_STEERING_ASSERT_SVH
`define LINE_SENSOR_PD_STEERING_ASSERT_SVH

// Checked only while the block is out of reset.
`define LSPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("line_sensor_pd_steering check failed");

// Checked at every edge, reset included.
`define LSPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("line_sensor_pd_steering check failed");

`endif

FILE: hw/rtl/lspd_pkg.sv
// Shared types and constants of the line sensor PD steering block.
package lspd_pkg;

    // Register map (index = byte address / 4).
    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [1:0] REG_BASE_SPEED = 2'd2;

    localparam logic [11:0] PROP_GAIN_RST  = 12'd1150;
    localparam logic [9:0]  DERIV_GAIN_RST = 10'd75;
    localparam logic [10:0] BASE_SPEED_RST = 11'd600;

    // Sensor patterns, bit i is sensor i.
    localparam logic [8:0] PAT_CENTRE  = 9'h038;
    localparam logic [8:0] PAT_POS3    = 9'h078;
    localparam logic [8:0] PAT_NEG3    = 9'h03C;
    localparam logic [8:0] PAT_POS5    = 9'h070;
    localparam logic [8:0] PAT_NEG5    = 9'h01C;
    localparam logic [8:0] PAT_POS8    = 9'h060;
    localparam logic [8:0] PAT_NEG8    = 9'h00C;
    localparam logic [8:0] EDGE_MASK   = 9'h183;
    localparam logic [8:0] EDGE_BRANCH = 9'h002;
    localparam logic [8:0] EDGE_HARD_L = 9'h003;
    localparam logic [8:0] EDGE_SOFT_R = 9'h080;
    localparam logic [8:0] EDGE_HARD_R = 9'h180;
    localparam logic [8:0] EDGE_NONE   = 9'h000;

    // Error values in tenths.
    localparam logic signed [5:0] ERR_ZERO  = 6'sd0;
    localparam logic signed [5:0] ERR_POS3  = 6'sd3;
    localparam logic signed [5:0] ERR_NEG3  = -6'sd3;
    localparam logic signed [5:0] ERR_POS5  = 6'sd5;
    localparam logic signed [5:0] ERR_NEG5  = -6'sd5;
    localparam logic signed [5:0] ERR_POS8  = 6'sd8;
    localparam logic signed [5:0] ERR_NEG8  = -6'sd8;
    localparam logic signed [5:0] ERR_POS14 = 6'sd14;
    localparam logic signed [5:0] ERR_NEG14 = -6'sd14;
    localparam logic signed [5:0] ERR_NEG25 = -6'sd25;
    localparam logic signed [5:0] ERR_POS15 = 6'sd15;
    localparam logic signed [5:0] ERR_POS25 = 6'sd25;

    // Branch counter values.
    localparam logic [1:0] BRANCH_NONE  = 2'd0;
    localparam logic [1:0] BRANCH_ONCE  = 2'd1;
    localparam logic [1:0] BRANCH_TWICE = 2'd2;

    // floor(m * DIV10_RECIP / 2^DIV10_SHIFT) equals floor(m / 10) for m < 2^18.
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [11:0] prop_gain;
        logic [9:0]  deriv_gain;
        logic [10:0] base_speed;
    } cfg_t;

    // Error of one sample and its change against the previous sample.
    typedef struct packed {
        logic signed [5:0] error_tenths;
        logic signed [6:0] error_delta;
    } err_stage_t;

    typedef struct packed {
        logic signed [15:0] motor_four;
        logic signed [15:0] motor_three;
        logic signed [15:0] motor_two;
        logic signed [15:0] motor_one;
        logic signed [14:0] drive_value;
        logic signed [5:0]  error_tenths;
    } result_t;

endpackage

FILE: hw/rtl/lspd_cfg.sv
// APB register file holding the gains and the base speed.
module lspd_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lspd_pkg::cfg_t     cfg
);

    lspd_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain  <= lspd_pkg::PROP_GAIN_RST;
            cfg_reg.deriv_gain <= lspd_pkg::DERIV_GAIN_RST;
            cfg_reg.base_speed <= lspd_pkg::BASE_SPEED_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                lspd_pkg::REG_PROP_GAIN:  cfg_reg.prop_gain  <= pwdata[11:0];
                lspd_pkg::REG_DERIV_GAIN: cfg_reg.deriv_gain <= pwdata[9:0];
                lspd_pkg::REG_BASE_SPEED: cfg_reg.base_speed <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lspd_pkg::REG_PROP_GAIN:  prdata = {20'd0, cfg_reg.prop_gain};
            lspd_pkg::REG_DERIV_GAIN: prdata = {22'd0, cfg_reg.deriv_gain};
            lspd_pkg::REG_BASE_SPEED: prdata = {21'd0, cfg_reg.base_speed};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

FILE: hw/rtl/lspd_err.sv
// Input register, sensor pattern match and error state.
module lspd_err (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [8:0]            in_sensor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lspd_pkg::err_stage_t  out_err
);

    logic                 in_vld_reg;
    logic [8:0]           sensor_reg;
    logic                 err_vld_reg;
    lspd_pkg::err_stage_t err_reg;
    logic signed [5:0]    last_err_reg;
    logic [1:0]           branch_cnt_reg;

    logic                 load_in;
    logic                 load_err;
    logic signed [5:0]    err_next;
    logic [1:0]           branch_cnt_next;
    logic [8:0]           edge_bits;

    assign load_err  = in_vld_reg && (!err_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || load_err;
    assign load_in   = in_valid && in_ready;
    assign out_valid = err_vld_reg;
    assign out_err   = err_reg;
    assign edge_bits = sensor_reg & lspd_pkg::EDGE_MASK;

    // Exact patterns win; then the outer sensors decide; otherwise the error holds.
    always_comb begin
        branch_cnt_next = branch_cnt_reg;
        case (sensor_reg)
            lspd_pkg::PAT_CENTRE: err_next = lspd_pkg::ERR_ZERO;
            lspd_pkg::PAT_POS3:   err_next = lspd_pkg::ERR_POS3;
            lspd_pkg::PAT_NEG3:   err_next = lspd_pkg::ERR_NEG3;
            lspd_pkg::PAT_POS5:   err_next = lspd_pkg::ERR_POS5;
            lspd_pkg::PAT_NEG5:   err_next = lspd_pkg::ERR_NEG5;
            lspd_pkg::PAT_POS8:   err_next = lspd_pkg::ERR_POS8;
            lspd_pkg::PAT_NEG8:   err_next = lspd_pkg::ERR_NEG8;
            default: begin
                case (edge_bits)
                    lspd_pkg::EDGE_BRANCH: begin
                        // First sighting of the branch steers one way, later ones the other.
                        if (branch_cnt_reg == lspd_pkg::BRANCH_NONE) begin
                            err_next        = lspd_pkg::ERR_POS14;
                            branch_cnt_next = lspd_pkg::BRANCH_ONCE;
                        end else begin
                            err_next = lspd_pkg::ERR_NEG14;
                            if (branch_cnt_reg == lspd_pkg::BRANCH_ONCE) begin
                                branch_cnt_next = lspd_pkg::BRANCH_TWICE;
                            end
                        end
                    end
                    lspd_pkg::EDGE_HARD_L: err_next = lspd_pkg::ERR_NEG25;
                    lspd_pkg::EDGE_SOFT_R: err_next = lspd_pkg::ERR_POS15;
                    lspd_pkg::EDGE_HARD_R: err_next = lspd_pkg::ERR_POS25;
                    lspd_pkg::EDGE_NONE:   err_next = lspd_pkg::ERR_ZERO;
                    default:               err_next = last_err_reg;
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            err_vld_reg    <= 1'b0;
            last_err_reg   <= lspd_pkg::ERR_ZERO;
            branch_cnt_reg <= lspd_pkg::BRANCH_NONE;
        end else begin
            if (load_in) begin
                in_vld_reg <= 1'b1;
            end else if (load_err) begin
                in_vld_reg <= 1'b0;
            end
            if (load_err) begin
                err_vld_reg    <= 1'b1;
                last_err_reg   <= err_next;
                branch_cnt_reg <= branch_cnt_next;
            end else if (out_ready) begin
                err_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            sensor_reg <= in_sensor;
        end
        if (load_err) begin
            err_reg.error_tenths <= err_next;
            err_reg.error_delta  <= 7'(err_next) - 7'(last_err_reg);
        end
    end

endmodule

FILE: hw/rtl/lspd_pd.sv
// PD products, divide by ten and motor targets, ending in the result register.
module lspd_pd (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lspd_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lspd_pkg::err_stage_t  in_err,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lspd_pkg::result_t     out_res
);

    logic               sum_vld_reg;
    logic               sum_neg_reg;
    logic [17:0]        sum_mag_reg;
    logic signed [5:0]  sum_err_reg;
    logic               res_vld_reg;
    lspd_pkg::result_t  res_reg;

    logic               load_sum;
    logic               load_res;
    logic signed [19:0] prod_p;
    logic signed [19:0] prod_d;
    logic signed [19:0] sum_pd;
    logic [19:0]        sum_abs;
    logic [33:0]        quot_full;
    logic [14:0]        quot_mag;
    logic signed [14:0] drive;
    logic signed [15:0] drive_ext;
    logic signed [15:0] base_ext;
    logic signed [15:0] fwd;
    logic signed [15:0] diff;
    lspd_pkg::result_t  res_next;

    assign load_res  = sum_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready  = !sum_vld_reg || load_res;
    assign load_sum  = in_valid && in_ready;
    assign out_valid = res_vld_reg;
    assign out_res   = res_reg;

    // First stage: both products and their sum, kept as sign and magnitude.
    assign prod_p  = $signed({1'b0, cfg.prop_gain}) * in_err.error_tenths;
    assign prod_d  = $signed({1'b0, cfg.deriv_gain}) * in_err.error_delta;
    assign sum_pd  = prod_p + prod_d;
    assign sum_abs = sum_pd[19] ? 20'(-sum_pd) : 20'(sum_pd);

    // Second stage: reciprocal multiply truncates the magnitude, so the sign is applied after.
    assign quot_full = 34'(sum_mag_reg) * 34'(lspd_pkg::DIV10_RECIP);
    assign quot_mag  = quot_full[lspd_pkg::DIV10_SHIFT +: 15];
    assign drive     = sum_neg_reg ? 15'(-$signed(quot_mag)) : $signed(quot_mag);
    assign drive_ext = 16'(drive);
    assign base_ext  = $signed({5'd0, cfg.base_speed});
    assign fwd       = base_ext + drive_ext;
    assign diff      = drive_ext - base_ext;

    always_comb begin
        res_next.error_tenths = sum_err_reg;
        res_next.drive_value  = drive;
        res_next.motor_one    = -fwd;
        res_next.motor_two    = diff;
        res_next.motor_three  = fwd;
        res_next.motor_four   = diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            if (load_sum) begin
                sum_vld_reg <= 1'b1;
            end else if (load_res) begin
                sum_vld_reg <= 1'b0;
            end
            if (load_res) begin
                res_vld_reg <= 1'b1;
            end else if (out_ready) begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_sum) begin
            sum_neg_reg <= sum_pd[19];
            sum_mag_reg <= sum_abs[17:0];
            sum_err_reg <= in_err.error_tenths;
        end
        if (load_res) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: hw/rtl/line_sensor_pd_steering.sv
// Top level of the line sensor PD steering block.
//
//  Port group   Direction  Carries
//  s_*          in         one nine-bit sensor sample per request
//  m_*          out        error, drive value and four motor targets per request
//  APB          in/out     prop_gain, deriv_gain, base_speed at 0x0, 0x4, 0x8
//
// One request is taken in every cycle unless m_tready stalls the output; each result
// leaves through a four-stage pipeline (input, pattern match, products, divide).
// Reset is synchronous and active low; it empties the pipeline and clears the
// held error and the branch counter.
// Each stage loads when it is empty or its successor loads, so stalls on m_tready
// fill the bubbles before they reach s_tready.
module line_sensor_pd_steering (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] sensor_bits, [15:9] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] error_tenths, [20:6] drive_value, [36:21] motor_one, [52:37] motor_two,
    // [68:53] motor_three, [84:69] motor_four, [87:85] zero
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lspd_pkg::cfg_t       cfg;
    lspd_pkg::err_stage_t err_stage;
    lspd_pkg::result_t    res;
    logic                 err_valid;
    logic                 err_ready;

    lspd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lspd_err u_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sensor (s_tdata[8:0]),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_err   (err_stage)
    );

    lspd_pd u_pd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_err    (err_stage),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {3'd0, res};

endmodule

FILE: hw/rtl/lspd_chk.sv
// Port-level checks of the line sensor PD steering block, bound to the top level.
`include "line_sensor_pd_steering_assert.svh"

module lspd_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    logic        stalled;
    logic [15:0] motor_one;
    logic [15:0] motor_two;
    logic [15:0] motor_three;
    logic [15:0] motor_four;
    logic [2:0]  tdata_pad;

    assign stalled     = m_tvalid && !m_tready;
    assign motor_one   = m_tdata[36:21];
    assign motor_two   = m_tdata[52:37];
    assign motor_three = m_tdata[68:53];
    assign motor_four  = m_tdata[84:69];
    assign tdata_pad   = m_tdata[87:85];

    // No result may appear in the cycle after a reset cycle.
    `LSPD_ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> !m_tvalid)

    // A result that is not taken stays as it is.
    `LSPD_ASSERT(a_stall_hold, aclk, aresetn, stalled |=> m_tvalid && $stable(m_tdata))

    // The first and third motors are mirror images.
    `LSPD_ASSERT(a_motor_mirror, aclk, aresetn, m_tvalid |-> 16'(motor_three + motor_one) == 16'd0)

    // The second and fourth motors agree and the padding stays clear.
    `LSPD_ASSERT(a_motor_pair, aclk, aresetn, m_tvalid |-> motor_four == motor_two && tdata_pad == 3'd0)

endmodule

bind line_sensor_pd_steering lspd_chk u_lspd_chk (.*);

FILE: verif/line_sensor_pd_steering_checker.sv
// Checker for the line sensor PD steering block: predicts each result and compares it.
`timescale 1ns / 100ps

module line_sensor_pd_steering_checker
    import lspd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] sensor_bits, [15:9] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] error_tenths, [20:6] drive_value, [36:21] motor_one, [52:37] motor_two,
    // [68:53] motor_three, [84:69] motor_four, [87:85] zero
    input  logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);

    logic [11:0]       gain_p;
    logic [9:0]        gain_d;
    logic [10:0]       speed_base;
    logic signed [5:0] held_error;
    logic [1:0]        branch_seen;
    result_t           steer_expected [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        if (fail_count < 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
            note_mismatch(what, want, got);
    endtask

    // Works out the steering result of one sample and moves the held error and
    // the branch counter on, as the block does.
    function automatic result_t predict_steering(input logic [8:0] sample);
        logic signed [5:0] err;
        int                pd_sum;
        int                drive;
        int                base;
        result_t           r;
        case (sample)
            PAT_CENTRE: err = ERR_ZERO;
            PAT_POS3:   err = ERR_POS3;
            PAT_NEG3:   err = ERR_NEG3;
            PAT_POS5:   err = ERR_POS5;
            PAT_NEG5:   err = ERR_NEG5;
            PAT_POS8:   err = ERR_POS8;
            PAT_NEG8:   err = ERR_NEG8;
            default: begin
                case (sample & EDGE_MASK)
                    EDGE_BRANCH: begin
                        // The first branch ever seen steers one way, every later one the other.
                        if (branch_seen == BRANCH_NONE) begin
                            err = ERR_POS14;
                            branch_seen = BRANCH_ONCE;
                        end else begin
                            err = ERR_NEG14;
                            if (branch_seen == BRANCH_ONCE)
                                branch_seen = BRANCH_TWICE;
                        end
                    end
                    EDGE_HARD_L: err = ERR_NEG25;
                    EDGE_SOFT_R: err = ERR_POS15;
                    EDGE_HARD_R: err = ERR_POS25;
                    EDGE_NONE:   err = ERR_ZERO;
                    default:     err = held_error;
                endcase
            end
        endcase
        pd_sum = int'(gain_p) * int'(err) + int'(gain_d) * (int'(err) - int'(held_error));
        // Integer division truncates toward zero, as the drive value requires.
        drive = pd_sum / 10;
        base = int'(speed_base);
        held_error = err;
        r.error_tenths = err;
        r.drive_value  = 15'(drive);
        r.motor_one    = 16'(-(base + drive));
        r.motor_two    = 16'(-(base - drive));
        r.motor_three  = 16'(base + drive);
        r.motor_four   = 16'(-(base - drive));
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            gain_p      = PROP_GAIN_RST;
            gain_d      = DERIV_GAIN_RST;
            speed_base  = BASE_SPEED_RST;
            held_error  = ERR_ZERO;
            branch_seen = BRANCH_NONE;
            steer_expected.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    // Writes beyond the last register are ignored.
                    case (paddr[3:2])
                        REG_PROP_GAIN:  gain_p     = pwdata[11:0];
                        REG_DERIV_GAIN: gain_d     = pwdata[9:0];
                        REG_BASE_SPEED: speed_base = pwdata[10:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        REG_PROP_GAIN:  check_field("prop_gain read", int'(gain_p), int'(prdata));
                        REG_DERIV_GAIN: check_field("deriv_gain read", int'(gain_d), int'(prdata));
                        REG_BASE_SPEED:
                            check_field("base_speed read", int'(speed_base), int'(prdata));
                        default: ;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                steer_expected.push_back(predict_steering(s_tdata[8:0]));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[84:0]);
                if (steer_expected.size() == 0) begin
                    note_mismatch("unexpected result, error_tenths", 0, int'(got.error_tenths));
                end else begin
                    want = steer_expected.pop_front();
                    check_field("error_tenths", int'(want.error_tenths), int'(got.error_tenths));
                    check_field("drive_value", int'(want.drive_value), int'(got.drive_value));
                    check_field("motor_one", int'(want.motor_one), int'(got.motor_one));
                    check_field("motor_two", int'(want.motor_two), int'(got.motor_two));
                    check_field("motor_three", int'(want.motor_three), int'(got.motor_three));
                    check_field("motor_four", int'(want.motor_four), int'(got.motor_four));
                    check_field("tdata padding", 0, int'(m_tdata[87:85]));
                end
            end
        end
        outstanding <= steer_expected.size();
    end

endmodule

FILE: verif/line_sensor_pd_steering_tb.sv
// Testbench top for the line sensor PD steering block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module line_sensor_pd_steering_tb;
    import lspd_pkg::*;

    localparam int         QUIET_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 215;
    localparam logic [3:0] ADDR_PROP_GAIN  = {REG_PROP_GAIN, 2'b00};
    localparam logic [3:0] ADDR_DERIV_GAIN = {REG_DERIV_GAIN, 2'b00};
    localparam logic [3:0] ADDR_BASE_SPEED = {REG_BASE_SPEED, 2'b00};
    localparam logic [3:0] ADDR_UNMAPPED   = 4'hC;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [8:0] sensor_bits, [15:9] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [5:0] error_tenths, [20:6] drive_value, [36:21] motor_one, [52:37] motor_two,
    // [68:53] motor_three, [84:69] motor_four, [87:85] zero
    logic [87:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    line_sensor_pd_steering dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    line_sensor_pd_steering_checker steer_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when no request moves on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [8:0] bits);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, bits};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the sender back until every result has come out and the pipeline is empty.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed line shapes, with the middle sensors free on edge shapes.
    function automatic logic [8:0] pick_sample();
        int          kind;
        logic [8:0]  bits;
        kind = $urandom_range(99);
        if (kind < 35) begin
            case ($urandom_range(6))
                0: bits = PAT_CENTRE;
                1: bits = PAT_POS3;
                2: bits = PAT_NEG3;
                3: bits = PAT_POS5;
                4: bits = PAT_NEG5;
                5: bits = PAT_POS8;
                default: bits = PAT_NEG8;
            endcase
        end else if (kind < 75) begin
            case ($urandom_range(4))
                0: bits = EDGE_BRANCH;
                1: bits = EDGE_HARD_L;
                2: bits = EDGE_SOFT_R;
                3: bits = EDGE_HARD_R;
                default: bits = EDGE_NONE;
            endcase
            bits = bits | (9'($urandom) & ~EDGE_MASK);
        end else begin
            bits = 9'($urandom);
        end
        return bits;
    endfunction

    initial begin
        logic [8:0]  directed_samples [$];
        logic [11:0] prop_set [PHASES];
        logic [9:0]  deriv_set [PHASES];
        logic [10:0] speed_set [PHASES];
        directed_samples = '{
            PAT_CENTRE, PAT_POS3, PAT_NEG3, PAT_POS5, PAT_NEG5, PAT_POS8, PAT_NEG8,
            EDGE_BRANCH, EDGE_BRANCH | 9'h07C, EDGE_BRANCH | 9'h028,
            EDGE_HARD_L, EDGE_HARD_L | 9'h07C, EDGE_SOFT_R, EDGE_HARD_R | 9'h054,
            EDGE_NONE, 9'h07C, EDGE_HARD_R, 9'h001, 9'h183, 9'h1FF, 9'h101,
            EDGE_HARD_L, 9'h100
        };
        prop_set  = '{PROP_GAIN_RST, 12'd4095, 12'd0, 12'($urandom), 12'd4095, 12'd0};
        deriv_set = '{DERIV_GAIN_RST, 10'd1023, 10'd0, 10'($urandom), 10'd0, 10'd1023};
        speed_set = '{BASE_SPEED_RST, 11'd2047, 11'd0, 11'($urandom), 11'd0, 11'd2047};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first branch sighting only happens once per reset, so it is covered here.
        foreach (directed_samples[i])
            send_sample(directed_samples[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                quiesce();
                // Upper data bits carry noise; only the register's own width may be kept.
                apb_access(1'b1, ADDR_PROP_GAIN, {20'($urandom), prop_set[phase]});
                apb_access(1'b1, ADDR_DERIV_GAIN, {22'($urandom), deriv_set[phase]});
                apb_access(1'b1, ADDR_BASE_SPEED, {21'($urandom), speed_set[phase]});
                if (phase == 2)
                    apb_access(1'b1, ADDR_UNMAPPED, $urandom);
                apb_access(1'b0, ADDR_PROP_GAIN, '0);
                apb_access(1'b0, ADDR_DERIV_GAIN, '0);
                apb_access(1'b0, ADDR_BASE_SPEED, '0);
            end
            send_idle_pct  = (phase % 4 == 1) ? 66 : (phase % 4 == 3) ? 29 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 66 : (phase % 4 == 3) ? 29 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    quiesce();
                send_sample(pick_sample());
            end
        end

        quiesce();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: line_sensor_pd_steering.f
+incdir+hw/rtl
hw/rtl/lspd_pkg.sv
hw/rtl/lspd_cfg.sv
hw/rtl/lspd_err.sv
hw/rtl/lspd_pd.sv
hw/rtl/line_sensor_pd_steering.sv
hw/rtl/lspd_chk.sv
verif/line_sensor_pd_steering_checker.sv
verif/line_sensor_pd_steering_tb.sv
